// File: hdl/almrc_pkg.sv
// Shared types and constants of the audio level meter with ring capture.
package almrc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int BF_W        = 16;
  localparam int POS_W       = 13;
  localparam int DB_W        = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int CMP_W       = 14;
  localparam int SQ_W        = 62;
  localparam int MC_W        = 17;
  localparam int LG_W        = 22;
  localparam int NDB_W       = 23;
  localparam int KDB_W       = 19;
  localparam int PROD_W      = NDB_W + KDB_W;

  localparam logic [SQ_W-1:0]  SQ_MAX      = {SQ_W{1'b1}};
  localparam logic [MC_W-1:0]  CNT_MAX     = {MC_W{1'b1}};
  localparam logic [KDB_W-1:0] K20         = 19'd394567;
  localparam logic [KDB_W-1:0] K10         = 19'd197283;
  localparam int               DB_FLOOR    = 30720;
  localparam int               LOUD_FLOOR  = 17920;
  localparam int               LOUD_OFFSET = 177;
  // full-scale references in Q.16 log2: (bits-1) and twice that
  localparam int               PK_BASE     = (SAMPLE_BITS - 1) * 65536;
  localparam int               RM_BASE     = 2 * (SAMPLE_BITS - 1) * 65536;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_READ_AN = 2'd1,
    REQ_READ_SC = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_SCOPE    = 2'd2,
    REG_CHANNELS = 2'd3
  } reg_e;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_RING   = 1'b1;

endpackage

// File: hdl/almrc_if.sv
// Handshake channel interfaces: request items, result items, register writes.
interface almrc_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic signed [almrc_pkg::SAMPLE_BITS-1:0] sample;
  logic [almrc_pkg::BF_W-1:0]             block_frames;
  logic [almrc_pkg::POS_W-1:0]            position;
  modport source (output valid, req_type, sample, block_frames, position, input ready);
  modport sink   (input valid, req_type, sample, block_frames, position, output ready);
endinterface

interface almrc_res_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [almrc_pkg::DB_W-1:0]      peak_db;
  logic signed [almrc_pkg::DB_W-1:0]      rms_db;
  logic signed [almrc_pkg::DB_W-1:0]      loudness_db;
  logic signed [almrc_pkg::SAMPLE_BITS-1:0] ring_sample;
  modport source (output valid, kind, peak_db, rms_db, loudness_db, ring_sample, input ready);
  modport sink   (input valid, kind, peak_db, rms_db, loudness_db, ring_sample, output ready);
endinterface

interface almrc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [almrc_pkg::CFG_IDX_W-1:0]    index;
  logic [almrc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/almrc_ram.sv
// Generic simple dual-port RAM with registered read.
module almrc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/almrc_log2.sv
// Iterative log2 in Q.16: bit-serial normalize, then one squaring per cycle.
module almrc_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                value,
  output logic                       done,
  output logic [almrc_pkg::LG_W-1:0] result
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t     st;
  logic [63:0] v;
  logic [5:0]  e;
  logic [30:0] m;
  logic [15:0] frac;
  logic [3:0]  it;
  logic [61:0] sq;
  logic [31:0] mm;

  assign sq     = 62'(m) * 62'(m);
  assign mm     = sq[61:30];
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        L_IDLE: begin
          if (start) begin
            v  <= value;
            e  <= 6'd63;
            st <= L_NORM;
          end
        end
        L_NORM: begin
          if (v[63] || e == 6'd0) begin
            m    <= v[63:33];
            frac <= '0;
            it   <= '0;
            st   <= L_SQ;
          end else begin
            v <= {v[62:0], 1'b0};
            e <= e - 6'd1;
          end
        end
        L_SQ: begin
          frac <= {frac[14:0], mm[31]};
          m    <= mm[31] ? mm[31:1] : mm[30:0];
          it   <= it + 4'd1;
          if (it == 4'd15) begin
            done <= 1'b1;
            st   <= L_IDLE;
          end
        end
        default: st <= L_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/audio_level_meter_ring_capture.sv
// Top level: peak / RMS level meter with analysis and scope capture rings.
//
// Channels: req (sink) carries sample, ring-read and clear items; res (source)
// carries level reports (kind 0) and ring read data (kind 1); cfg (sink) takes
// register writes (enable, window_frames, scope_points, channel_count) at any
// cycle, to be issued only while the block is idle.
// Throughput: one item at a time. A sample item that does not close a frame
// passes S_ACC and S_MEAS; one that closes a frame adds the serial mono
// divider (SAMPLE_BITS + log2(MAX_CHANNELS) quotient bits) and a ring write.
// A frame that closes the block runs three log2 passes on the shared log2
// unit (bit-serial normalize, then squaring) plus the dB product and result
// steps. Ring reads go through the address, the registered RAM read and the
// output load. Clear gives no result.
// Each ring lives in its own RAM; write then read of an entry never overlap.
// Results go through a one-entry output register; a new item is accepted
// while a result waits, but an item with a result holds until the register
// frees, so a stalled receiver eventually stalls req.
// Reset clears pointers, fills, counters and the output; ring contents are
// left as they are and read only where filled.
module audio_level_meter_ring_capture #(
  parameter int MAX_WINDOW   = 8192,
  parameter int MAX_SCOPE    = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  almrc_req_if.sink   req,
  almrc_res_if.source res,
  almrc_cfg_if.sink   cfg
);

  localparam int SB      = almrc_pkg::SAMPLE_BITS;
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int WLW     = AW + 1;
  localparam int SW      = $clog2(MAX_SCOPE);
  localparam int SLW     = $clog2(MAX_SCOPE + 1);
  localparam int CCW     = $clog2(MAX_CHANNELS + 1);
  localparam int CTW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ACC_W   = SB + $clog2(MAX_CHANNELS);
  localparam int DCW     = $clog2(ACC_W + 1);
  localparam int NCAND   = AW - 5;
  localparam int WIN_RST = (MAX_WINDOW < 2048) ? MAX_WINDOW : 2048;
  localparam int SCP_RST = (MAX_SCOPE < 1024) ? MAX_SCOPE : 1024;
  localparam int CH_RST  = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;
  localparam int CW      = almrc_pkg::CMP_W;
  localparam int BW      = almrc_pkg::BF_W;
  localparam int DW      = almrc_pkg::DB_W;
  localparam int PW      = almrc_pkg::PROD_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_ACC    = 11'b00000000010,
    S_MEAS   = 11'b00000000100,
    S_DIV    = 11'b00000001000,
    S_WR     = 11'b00000010000,
    S_LSTART = 11'b00000100000,
    S_LWAIT  = 11'b00001000000,
    S_DB     = 11'b00010000000,
    S_FIN    = 11'b00100000000,
    S_RD     = 11'b01000000000,
    S_PUT    = 11'b10000000000
  } state_t;

  // nearest power of two in 64..MAX_WINDOW, tie goes to the smaller one
  function automatic logic [WLW-1:0] near_pow2(input logic [CW-1:0] val);
    logic [CW:0] best, bd, c, d;
    best = (CW+1)'(64);
    bd   = ((CW+1)'(val) > best) ? (CW+1)'(val) - best : best - (CW+1)'(val);
    for (int i = 1; i < NCAND; i++) begin
      c = (CW+1)'(64) << i;
      d = ((CW+1)'(val) > c) ? (CW+1)'(val) - c : c - (CW+1)'(val);
      if (d < bd) begin
        best = c;
        bd   = d;
      end
    end
    return WLW'(best);
  endfunction

  // registers
  logic           en;
  logic [WLW-1:0] win;
  logic [SLW-1:0] scp;
  logic [CCW-1:0] chn;

  state_t st;

  // item capture
  logic signed [SB-1:0] s_r;
  logic [BW-1:0]        bf_r;
  logic                 in_an, in_sc;
  logic [SB-1:0]        mag_r;
  logic [2*SB-1:0]      sq_r;

  // block accumulation
  logic [BW-1:0]                fc;
  logic [CTW-1:0]               cc;
  logic signed [ACC_W-1:0]      acc;
  logic [SB-1:0]                peak;
  logic [almrc_pkg::SQ_W-1:0]   ss;
  logic [almrc_pkg::MC_W-1:0]   mc;

  // ring pointers
  logic [AW-1:0]  an_wp;
  logic [WLW-1:0] an_fill;
  logic [SW-1:0]  sc_wp;
  logic [SLW-1:0] sc_fill;

  // serial divider
  logic [ACC_W-1:0] dq;
  logic [CCW-1:0]   drem;
  logic [DCW-1:0]   dcnt;
  logic             dneg;
  logic [CCW:0]     dshift;
  logic             dbit;

  // level math
  logic [1:0]                 lsel;
  logic [almrc_pkg::LG_W-1:0] lg_pk, lg_cnt, lg_sum, lg_res;
  logic                       lg_start, lg_done;
  logic [63:0]                lg_val;
  logic [PW-1:0]              prod_pk, prod_rm;

  // ring read bookkeeping
  logic rd_sel, rd_ok;

  // pending result and output register
  logic                 p_kind;
  logic signed [DW-1:0] p_pk, p_rm, p_ld;
  logic signed [SB-1:0] p_rs;
  logic                 o_valid, o_kind;
  logic signed [DW-1:0] o_pk, o_rm, o_ld;
  logic signed [SB-1:0] o_rs;

  // combinational helpers
  almrc_pkg::req_e      rtype;
  logic                 accept;
  logic [AW-1:0]        an_mask, an_ridx;
  logic [SW:0]          sc_sum;
  logic [SW-1:0]        sc_ridx;
  logic                 an_ok, sc_ok;
  logic [BW-1:0]        an_start, sc_start;
  logic [SB-1:0]        mag_c;
  logic [almrc_pkg::SQ_W:0] ss_sum;
  logic [BW:0]          fc_inc;
  logic signed [SB-1:0] mono;
  logic                 an_we, sc_we;
  logic [SB-1:0]        an_rdata, sc_rdata;
  logic signed [23:0]   n_pk_s, n_rm_s;
  logic [almrc_pkg::NDB_W-1:0] n_pk, n_rm;
  logic [PW-1:0]        r_pk, r_rm;
  logic [DW-1:0]        mag_pk, mag_rm;
  logic signed [DW-1:0] db_pk, db_rm;
  logic signed [DW:0]   ld_c;

  assign rtype  = almrc_pkg::req_e'(req.req_type);
  assign accept = req.valid && req.ready;
  assign req.ready = (st == S_IDLE);
  assign cfg.ready = 1'b1;

  // analysis ring: power-of-two length, wrap by mask
  assign an_mask = AW'(win - WLW'(1));
  assign an_ridx = AW'(an_wp + req.position[AW-1:0]) & an_mask;
  assign an_ok   = (CW'(req.position) < CW'(win)) &&
                   (CW'(req.position) >= CW'(win) - CW'(an_fill));

  // scope ring: arbitrary length, one conditional subtract
  assign sc_sum  = (SW+1)'(sc_wp) + (SW+1)'(req.position[SW-1:0]);
  assign sc_ridx = (sc_sum >= (SW+1)'(scp)) ? SW'(sc_sum - (SW+1)'(scp)) : SW'(sc_sum);
  assign sc_ok   = (CW'(req.position) < CW'(scp)) &&
                   (CW'(req.position) >= CW'(scp) - CW'(sc_fill));

  assign an_start = (bf_r > BW'(win)) ? bf_r - BW'(win) : '0;
  assign sc_start = (bf_r > BW'(scp)) ? bf_r - BW'(scp) : '0;
  assign mag_c    = s_r[SB-1] ? SB'(-s_r) : SB'(s_r);
  assign ss_sum   = {1'b0, ss} + (almrc_pkg::SQ_W+1)'(sq_r);
  assign fc_inc   = (BW+1)'(fc) + (BW+1)'(1);

  assign dshift = {drem, dq[ACC_W-1]};
  assign dbit   = (dshift >= (CCW+1)'(chn));

  assign mono  = dneg ? SB'(-dq) : SB'(dq);
  assign an_we = (st == S_WR) && in_an;
  assign sc_we = (st == S_WR) && in_sc;

  always_comb begin
    unique case (lsel)
      2'd0:    lg_val = 64'(peak);
      2'd1:    lg_val = 64'(mc);
      default: lg_val = 64'(ss);
    endcase
  end
  assign lg_start = (st == S_LSTART);

  // dB conversion
  assign n_pk_s = 24'(almrc_pkg::PK_BASE) - 24'(lg_pk);
  assign n_rm_s = 24'(almrc_pkg::RM_BASE) + 24'(lg_cnt) - 24'(lg_sum);
  assign n_pk   = n_pk_s[23] ? '0 : n_pk_s[almrc_pkg::NDB_W-1:0];
  assign n_rm   = n_rm_s[23] ? '0 : n_rm_s[almrc_pkg::NDB_W-1:0];
  assign r_pk   = (prod_pk + PW'(1 << 23)) >> 24;
  assign r_rm   = (prod_rm + PW'(1 << 23)) >> 24;
  assign mag_pk = (r_pk > PW'(almrc_pkg::DB_FLOOR)) ? DW'(almrc_pkg::DB_FLOOR) : DW'(r_pk);
  assign mag_rm = (r_rm > PW'(almrc_pkg::DB_FLOOR)) ? DW'(almrc_pkg::DB_FLOOR) : DW'(r_rm);
  assign db_pk  = (peak == '0) ? -DW'(almrc_pkg::DB_FLOOR) : -mag_pk;
  assign db_rm  = (ss == '0 || mc == '0) ? -DW'(almrc_pkg::DB_FLOOR) : -mag_rm;
  assign ld_c   = (DW+1)'(db_rm) - (DW+1)'(almrc_pkg::LOUD_OFFSET);

  almrc_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_an_ring (
    .clk   (clk),
    .we    (an_we),
    .waddr (an_wp),
    .wdata (mono),
    .raddr (an_ridx),
    .rdata (an_rdata)
  );

  almrc_ram #(.WIDTH(SB), .DEPTH(MAX_SCOPE)) u_sc_ring (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_wp),
    .wdata (mono),
    .raddr (sc_ridx),
    .rdata (sc_rdata)
  );

  almrc_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (lg_start),
    .value  (lg_val),
    .done   (lg_done),
    .result (lg_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      en      <= 1'b1;
      win     <= WLW'(WIN_RST);
      scp     <= SLW'(SCP_RST);
      chn     <= CCW'(CH_RST);
      st      <= S_IDLE;
      fc      <= '0;
      cc      <= '0;
      acc     <= '0;
      peak    <= '0;
      ss      <= '0;
      mc      <= '0;
      an_wp   <= '0;
      an_fill <= '0;
      sc_wp   <= '0;
      sc_fill <= '0;
      o_valid <= 1'b0;
    end else begin
      // output register
      if (st == S_PUT && (!o_valid || res.ready)) begin
        o_valid <= 1'b1;
        o_kind  <= p_kind;
        o_pk    <= p_pk;
        o_rm    <= p_rm;
        o_ld    <= p_ld;
        o_rs    <= p_rs;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (accept) begin
            unique case (rtype)
              almrc_pkg::REQ_READ_AN,
              almrc_pkg::REQ_READ_SC: begin
                rd_sel <= (rtype == almrc_pkg::REQ_READ_SC);
                rd_ok  <= (rtype == almrc_pkg::REQ_READ_SC) ? sc_ok : an_ok;
                st     <= S_RD;
              end
              almrc_pkg::REQ_CLEAR: begin
                an_wp   <= '0;
                an_fill <= '0;
                sc_wp   <= '0;
                sc_fill <= '0;
                fc      <= '0;
                cc      <= '0;
                acc     <= '0;
                peak    <= '0;
                ss      <= '0;
                mc      <= '0;
              end
              almrc_pkg::REQ_SAMPLE: begin
                if (en && chn != '0) begin
                  s_r  <= req.sample;
                  bf_r <= (req.block_frames == '0) ? BW'(1) : req.block_frames;
                  st   <= S_ACC;
                end
              end
              default: st <= S_IDLE;
            endcase
          end
        end
        S_ACC: begin
          acc   <= acc + ACC_W'(s_r);
          in_an <= (fc >= an_start);
          in_sc <= (fc >= sc_start);
          mag_r <= mag_c;
          sq_r  <= mag_c * mag_c;
          st    <= S_MEAS;
        end
        S_MEAS: begin
          if (in_an) begin
            if (mag_r > peak) begin
              peak <= mag_r;
            end
            ss <= ss_sum[almrc_pkg::SQ_W] ? almrc_pkg::SQ_MAX : ss_sum[almrc_pkg::SQ_W-1:0];
            if (mc != almrc_pkg::CNT_MAX) begin
              mc <= mc + 1'b1;
            end
          end
          if ((CCW+1)'(cc) + (CCW+1)'(1) < (CCW+1)'(chn)) begin
            cc <= cc + 1'b1;
            st <= S_IDLE;
          end else begin
            dneg <= acc[ACC_W-1];
            dq   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
            drem <= '0;
            dcnt <= '0;
            st   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division of |sum| by the channel count, one bit a cycle
          drem <= dbit ? CCW'(dshift - (CCW+1)'(chn)) : CCW'(dshift);
          dq   <= {dq[ACC_W-2:0], dbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(ACC_W - 1)) begin
            st <= S_WR;
          end
        end
        S_WR: begin
          if (in_an) begin
            an_wp <= AW'(an_wp + AW'(1)) & an_mask;
            if (an_fill < win) begin
              an_fill <= an_fill + 1'b1;
            end
          end
          if (in_sc) begin
            sc_wp <= ((SW+1)'(sc_wp) + (SW+1)'(1) == (SW+1)'(scp)) ? '0 : sc_wp + 1'b1;
            if (sc_fill < scp) begin
              sc_fill <= sc_fill + 1'b1;
            end
          end
          cc  <= '0;
          acc <= '0;
          if (fc_inc < (BW+1)'(bf_r)) begin
            fc <= BW'(fc_inc);
            st <= S_IDLE;
          end else begin
            lsel <= 2'd0;
            st   <= S_LSTART;
          end
        end
        S_LSTART: begin
          st <= S_LWAIT;
        end
        S_LWAIT: begin
          if (lg_done) begin
            unique case (lsel)
              2'd0:    lg_pk  <= lg_res;
              2'd1:    lg_cnt <= lg_res;
              default: lg_sum <= lg_res;
            endcase
            if (lsel == 2'd2) begin
              st <= S_DB;
            end else begin
              lsel <= lsel + 2'd1;
              st   <= S_LSTART;
            end
          end
        end
        S_DB: begin
          prod_pk <= n_pk * almrc_pkg::K20;
          prod_rm <= n_rm * almrc_pkg::K10;
          st      <= S_FIN;
        end
        S_FIN: begin
          p_kind <= almrc_pkg::KIND_REPORT;
          p_pk   <= db_pk;
          p_rm   <= db_rm;
          p_ld   <= (ld_c < -(DW+1)'(almrc_pkg::LOUD_FLOOR)) ?
                    -DW'(almrc_pkg::LOUD_FLOOR) : DW'(ld_c);
          p_rs   <= '0;
          fc     <= '0;
          cc     <= '0;
          acc    <= '0;
          peak   <= '0;
          ss     <= '0;
          mc     <= '0;
          st     <= S_PUT;
        end
        S_RD: begin
          p_kind <= almrc_pkg::KIND_RING;
          p_pk   <= '0;
          p_rm   <= '0;
          p_ld   <= '0;
          p_rs   <= rd_ok ? (rd_sel ? sc_rdata : an_rdata) : '0;
          st     <= S_PUT;
        end
        S_PUT: begin
          if (!o_valid || res.ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase

      // register writes
      if (cfg.valid) begin
        unique case (almrc_pkg::reg_e'(cfg.index))
          almrc_pkg::REG_ENABLE: en <= cfg.data[0];
          almrc_pkg::REG_WINDOW: begin
            win     <= near_pow2(cfg.data);
            an_wp   <= '0;
            an_fill <= '0;
          end
          almrc_pkg::REG_SCOPE: begin
            if (cfg.data[12:0] == '0) begin
              scp <= (1024 > MAX_SCOPE) ? SLW'(MAX_SCOPE) : SLW'(1024);
            end else if (cfg.data[12:0] < 13'd64) begin
              scp <= SLW'(64);
            end else if (CW'(cfg.data[12:0]) > CW'(MAX_SCOPE)) begin
              scp <= SLW'(MAX_SCOPE);
            end else begin
              scp <= SLW'(cfg.data[12:0]);
            end
            sc_wp   <= '0;
            sc_fill <= '0;
          end
          almrc_pkg::REG_CHANNELS: begin
            chn  <= (CW'(cfg.data[3:0]) > CW'(MAX_CHANNELS)) ?
                    CCW'(MAX_CHANNELS) : CCW'(cfg.data[3:0]);
            fc   <= '0;
            cc   <= '0;
            acc  <= '0;
            peak <= '0;
            ss   <= '0;
            mc   <= '0;
          end
          default: en <= en;
        endcase
      end
    end
  end

  assign res.valid       = o_valid;
  assign res.kind        = o_kind;
  assign res.peak_db     = o_pk;
  assign res.rms_db      = o_rm;
  assign res.loudness_db = o_ld;
  assign res.ring_sample = o_rs;

endmodule

// File: hdl/almrc_checker.sv
// Port-level checks on the result channel, bound to the top level.
module almrc_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   res_valid,
  input logic                                   res_ready,
  input logic                                   res_kind,
  input logic signed [almrc_pkg::DB_W-1:0]      peak_db,
  input logic signed [almrc_pkg::DB_W-1:0]      rms_db,
  input logic signed [almrc_pkg::DB_W-1:0]      loudness_db,
  input logic signed [almrc_pkg::SAMPLE_BITS-1:0] ring_sample
);

  logic signed [almrc_pkg::DB_W:0] loud_raw;
  assign loud_raw = (almrc_pkg::DB_W+1)'(rms_db) - (almrc_pkg::DB_W+1)'(almrc_pkg::LOUD_OFFSET);

  a_read_db_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == almrc_pkg::KIND_RING |->
      peak_db == '0 && rms_db == '0 && loudness_db == '0)
    else $error("ring read item carries nonzero level fields");

  a_report_ring_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == almrc_pkg::KIND_REPORT |-> ring_sample == '0)
    else $error("level report carries ring data");

  a_loudness: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == almrc_pkg::KIND_REPORT |->
      (loud_raw >= -(almrc_pkg::DB_W+1)'(almrc_pkg::LOUD_FLOOR) &&
       (almrc_pkg::DB_W+1)'(loudness_db) == loud_raw) ||
      (loud_raw < -(almrc_pkg::DB_W+1)'(almrc_pkg::LOUD_FLOOR) &&
       loudness_db == -(almrc_pkg::DB_W)'(almrc_pkg::LOUD_FLOOR)))
    else $error("loudness does not follow rms level");

  a_db_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == almrc_pkg::KIND_REPORT |->
      peak_db <= 0 && peak_db >= -almrc_pkg::DB_FLOOR &&
      rms_db <= 0 && rms_db >= -almrc_pkg::DB_FLOOR)
    else $error("level out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(ring_sample) &&
      $stable(peak_db) && $stable(rms_db))
    else $error("result dropped or changed under stall");

endmodule

bind audio_level_meter_ring_capture almrc_checker u_almrc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_kind    (res.kind),
  .peak_db     (res.peak_db),
  .rms_db      (res.rms_db),
  .loudness_db (res.loudness_db),
  .ring_sample (res.ring_sample)
);

// File: tb/almrc_level_checker.sv
// Level meter checker: watches the channels, predicts results, compares them.
`timescale 1ns / 100ps

module almrc_level_checker
  import almrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  almrc_req_if        req,
  almrc_res_if        res,
  almrc_cfg_if        cfg,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic                         kind;
    logic [DB_W-1:0]              peak_db;
    logic [DB_W-1:0]              rms_db;
    logic [DB_W-1:0]              loud_db;
    logic [SAMPLE_BITS-1:0]       ring_sample;
  } level_result_t;

  level_result_t due_results[$];

  logic [SAMPLE_BITS-1:0] an_ring[8192];
  logic [SAMPLE_BITS-1:0] sc_ring[4096];
  int unsigned an_wp, an_fill, sc_wp, sc_fill, frames_done, chan_idx;
  longint mono_sum;
  longint unsigned peak_mag, sq_sum, meas_cnt;
  int unsigned en_reg, win_len, scope_len, chans;

  assign outstanding = due_results.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint log2_q16(input longint unsigned v);
    int e;
    longint unsigned m;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && v[e] == 1'b0) e--;
    m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic longint level_db(input longint n, input longint unsigned k);
    longint unsigned mag;
    if (n < 0) n = 0;
    mag = (longint'(n) * k + (64'd1 << 23)) >> 24;
    if (mag > DB_FLOOR) mag = DB_FLOOR;
    return -longint'(mag);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] ring_entry(input bit scope, input int unsigned pos);
    int unsigned len, wp, avail;
    len   = scope ? scope_len : win_len;
    wp    = scope ? sc_wp : an_wp;
    avail = scope ? sc_fill : an_fill;
    if (avail > len) avail = len;
    if (pos >= len || pos < len - avail) return '0;
    return scope ? sc_ring[(wp + pos) % len] : an_ring[(wp + pos) % len];
  endfunction

  task automatic restart_block();
    frames_done = 0;
    chan_idx = 0;
    mono_sum = 0;
    peak_mag = 0;
    sq_sum = 0;
    meas_cnt = 0;
  endtask

  task automatic apply_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] d);
    int unsigned best, bd, gap, v;
    case (idx)
      REG_ENABLE: en_reg = d[0];
      REG_WINDOW: begin
        v = d;
        best = 64;
        bd = (v > 64) ? v - 64 : 64 - v;
        for (int unsigned c = 64; c <= 8192; c = c << 1) begin
          gap = (v > c) ? v - c : c - v;
          if (gap < bd) begin
            best = c;
            bd = gap;
          end
        end
        win_len = best;
        an_wp = 0;
        an_fill = 0;
      end
      REG_SCOPE: begin
        v = d[12:0];
        if (v == 0) v = 1024;
        if (v < 64) v = 64;
        if (v > 4096) v = 4096;
        scope_len = v;
        sc_wp = 0;
        sc_fill = 0;
      end
      default: begin
        v = d[3:0];
        chans = (v > 8) ? 8 : v;
        restart_block();
      end
    endcase
  endtask

  // one accepted sample; queues a level report when it closes the block
  task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic [15:0] bf_in);
    int unsigned bf, an_start, sc_start;
    longint unsigned mag, sq;
    longint mono, pk, rm, ld;
    level_result_t r;
    if (en_reg == 0 || chans == 0) return;
    bf = (bf_in == 0) ? 1 : bf_in;
    an_start = (bf > win_len) ? bf - win_len : 0;
    sc_start = (bf > scope_len) ? bf - scope_len : 0;
    mono_sum += longint'(s);
    if (frames_done >= an_start) begin
      mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
      sq = mag * mag;
      if (mag > peak_mag) peak_mag = mag;
      sq_sum = (sq_sum > SQ_MAX - sq) ? SQ_MAX : sq_sum + sq;
      if (meas_cnt < CNT_MAX) meas_cnt++;
    end
    if (chan_idx + 1 < chans) begin
      chan_idx++;
      return;
    end
    mono = mono_sum / longint'(chans);
    if (frames_done >= an_start) begin
      an_ring[an_wp] = mono[SAMPLE_BITS-1:0];
      an_wp = (an_wp + 1) % win_len;
      if (an_fill < win_len) an_fill++;
    end
    if (frames_done >= sc_start) begin
      sc_ring[sc_wp] = mono[SAMPLE_BITS-1:0];
      sc_wp = (sc_wp + 1) % scope_len;
      if (sc_fill < scope_len) sc_fill++;
    end
    chan_idx = 0;
    mono_sum = 0;
    frames_done++;
    if (frames_done < bf) return;
    pk = (peak_mag == 0) ? -DB_FLOOR : level_db(PK_BASE - log2_q16(peak_mag), K20);
    if (sq_sum == 0 || meas_cnt == 0) rm = -DB_FLOOR;
    else rm = level_db(RM_BASE + log2_q16(meas_cnt) - log2_q16(sq_sum), K10);
    ld = rm - LOUD_OFFSET;
    if (ld < -LOUD_FLOOR) ld = -LOUD_FLOOR;
    r.kind = KIND_REPORT;
    r.peak_db = pk[DB_W-1:0];
    r.rms_db = rm[DB_W-1:0];
    r.loud_db = ld[DB_W-1:0];
    r.ring_sample = '0;
    due_results.insert(due_results.size(), r);
    restart_block();
  endtask

  always @(posedge clk) begin
    level_result_t r, want;
    if (rst) begin
      due_results.delete();
      an_wp = 0; an_fill = 0; sc_wp = 0; sc_fill = 0;
      restart_block();
      en_reg = 1; win_len = 2048; scope_len = 1024; chans = 2;
    end else begin
      if (cfg.valid && cfg.ready) apply_reg(reg_e'(cfg.index), cfg.data);
      if (req.valid && req.ready) begin
        case (req_e'(req.req_type))
          REQ_READ_AN, REQ_READ_SC: begin
            r = '0;
            r.kind = KIND_RING;
            r.ring_sample = ring_entry(req.req_type == REQ_READ_SC, req.position);
            due_results.insert(due_results.size(), r);
          end
          REQ_CLEAR: begin
            an_wp = 0; an_fill = 0; sc_wp = 0; sc_fill = 0;
            restart_block();
          end
          default: take_sample(req.sample, req.block_frames);
        endcase
      end
      if (res.valid && res.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result item with no expectation waiting", $realtime);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (res.kind !== want.kind) report_mismatch("kind", res.kind, want.kind);
          if (res.peak_db !== want.peak_db)
            report_mismatch("peak_db", res.peak_db, $signed(want.peak_db));
          if (res.rms_db !== want.rms_db)
            report_mismatch("rms_db", res.rms_db, $signed(want.rms_db));
          if (res.loudness_db !== want.loud_db)
            report_mismatch("loudness_db", res.loudness_db, $signed(want.loud_db));
          if (res.ring_sample !== want.ring_sample)
            report_mismatch("ring_sample", res.ring_sample, $signed(want.ring_sample));
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// File: tb/audio_level_meter_ring_capture_tb.sv
// Testbench top: clock, reset, stimulus for the level meter and the verdict.
`timescale 1ns / 100ps

module audio_level_meter_ring_capture_tb;
  import almrc_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left;
  int   sample_items;   // accepted sample items, counted also when the block ignores them
  int   stall_mode;

  almrc_req_if req_ch ();
  almrc_res_if res_ch ();
  almrc_cfg_if cfg_ch ();

  audio_level_meter_ring_capture uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  almrc_level_checker level_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: switches between always-ready, random stalls and long stalls
  initial begin
    int mode_left;
    res_ch.ready = 1'b0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        0: res_ch.ready = 1'b1;
        1, 2: res_ch.ready = $urandom_range(0, 1);
        default: res_ch.ready = ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // one item on the request channel; returns at the falling edge after it
  // was taken, with valid still high while the burst goes on
  task automatic put_item(input req_e t, input logic [SAMPLE_BITS-1:0] s,
                          input logic [BF_W-1:0] bf, input logic [POS_W-1:0] p);
    req_ch.valid = 1'b1;
    req_ch.req_type = t;
    req_ch.sample = s;
    req_ch.block_frames = bf;
    req_ch.position = p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (t == REQ_SAMPLE) sample_items++;
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // hold off until every expected result is back, then let the block settle
  task automatic drain();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      1: return 24'h0;
      2: return 24'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_read();
    if ($urandom_range(0, 1))
      put_item(REQ_READ_AN, $urandom, $urandom, $urandom);
    else
      put_item(REQ_READ_SC, $urandom, $urandom, $urandom);
  endtask

  // mostly whole blocks with random content; some reads, rare clears and
  // blocks whose frame count moves mid-way
  task automatic random_traffic(input int n_items, input int chans);
    int goal, bf, cap, roll;
    goal = sample_items + n_items;
    cap = (chans == 0) ? 8 : 90 / chans + 1;
    while (sample_items < goal) begin
      // occasionally a long block so old frames fall outside a small window
      bf = ($urandom_range(0, 15) == 0) ? $urandom_range(65, 150) : $urandom_range(1, cap);
      for (int f = 0; f < bf; f++) begin
        for (int c = 0; c < ((chans == 0) ? 1 : chans); c++) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) random_read();
          else if (roll == 8) put_item(REQ_CLEAR, $urandom, $urandom, $urandom);
          if (roll == 9)
            put_item(REQ_SAMPLE, pick_sample(), $urandom, $urandom);
          else
            put_item(REQ_SAMPLE, pick_sample(), bf, $urandom);
        end
      end
      // read back at random positions
      repeat ($urandom_range(0, 3))
        put_item($urandom_range(0, 1) ? REQ_READ_AN : REQ_READ_SC, $urandom, $urandom,
                 $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, 4095));
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SAMPLE;
    req_ch.sample = '0;
    req_ch.block_frames = '0;
    req_ch.position = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ENABLE;
    cfg_ch.data = '0;
    burst_left = 0;
    sample_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // directed: reads of empty rings, extremes, zero and one-frame blocks
    put_item(REQ_READ_AN, '0, '0, 13'd0);
    put_item(REQ_READ_SC, '0, '0, 13'h1FFF);
    put_item(REQ_SAMPLE, 24'h800000, 16'd1, '0);
    put_item(REQ_SAMPLE, 24'h7FFFFF, 16'd1, '0);   // full-scale frame, block of one
    put_item(REQ_SAMPLE, 24'h0, 16'd0, '0);
    put_item(REQ_SAMPLE, 24'h0, 16'd0, '0);        // silent block, zero frame count
    put_item(REQ_SAMPLE, 24'hFFFFFF, 16'd2, 13'h1FFF);
    put_item(REQ_SAMPLE, 24'h000001, 16'd2, '0);
    put_item(REQ_SAMPLE, 24'hFFFFFD, 16'd2, '0);
    put_item(REQ_SAMPLE, 24'h7FFFFF, 16'd2, '0);
    put_item(REQ_READ_AN, '0, '0, 13'd2047);
    put_item(REQ_READ_AN, '0, '0, 13'd2046);
    put_item(REQ_READ_SC, '0, '0, 13'd1023);
    put_item(REQ_READ_SC, '0, '0, 13'd1024);       // past the scope ring
    // partial block with the largest frame count, then cleared away
    put_item(REQ_SAMPLE, 24'h123456, 16'hFFFF, '0);
    put_item(REQ_SAMPLE, 24'hABCDEF, 16'hFFFF, '0);
    put_item(REQ_SAMPLE, 24'h555555, 16'hAAAA, '0);
    put_item(REQ_CLEAR, '0, '0, '0);
    put_item(REQ_READ_AN, '0, '0, 13'd2047);
    put_item(REQ_SAMPLE, 24'h400000, 16'd1, '0);
    put_item(REQ_SAMPLE, 24'hC00000, 16'd1, '0);
    drain();

    random_traffic(150, 2);

    // one pause mid-phase until every result is back
    drain();
    random_traffic(60, 2);
    drain();

    // smallest window and scope, mono
    write_reg(REG_WINDOW, 14'd0);
    write_reg(REG_SCOPE, 14'd5);
    write_reg(REG_CHANNELS, 14'd1);
    random_traffic(200, 1);
    drain();

    // largest settings, channel count above the limit saturates
    write_reg(REG_WINDOW, 14'h3FFF);
    write_reg(REG_SCOPE, 14'h1FFF);
    write_reg(REG_CHANNELS, 14'd15);
    random_traffic(220, 8);
    drain();

    // capture off: samples ignored, reads still answered
    write_reg(REG_ENABLE, 14'd0);
    repeat (20) put_item(REQ_SAMPLE, pick_sample(), 16'd1, $urandom);
    repeat (6) random_read();
    drain();

    // back on; zero channels ignores samples
    write_reg(REG_ENABLE, 14'h3FFF);
    write_reg(REG_CHANNELS, 14'd0);
    repeat (20) put_item(REQ_SAMPLE, pick_sample(), 16'd1, $urandom);
    repeat (6) random_read();
    drain();

    // tie between 64 and 128, scope zero meaning default, odd channel count
    write_reg(REG_WINDOW, 14'd96);
    write_reg(REG_SCOPE, 14'd0);
    write_reg(REG_CHANNELS, 14'd3);
    random_traffic(200, 3);
    drain();

    write_reg(REG_WINDOW, 14'd300);
    write_reg(REG_SCOPE, 14'd100);
    write_reg(REG_CHANNELS, 14'd5);
    random_traffic(200, 5);
    drain();

    write_reg(REG_WINDOW, 14'd8192);
    write_reg(REG_SCOPE, 14'd4096);
    write_reg(REG_CHANNELS, 14'd2);
    random_traffic(200, 2);
    drain();

    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
hdl/almrc_pkg.sv
hdl/almrc_if.sv
hdl/almrc_ram.sv
hdl/almrc_log2.sv
hdl/audio_level_meter_ring_capture.sv
hdl/almrc_checker.sv
tb/almrc_level_checker.sv
tb/audio_level_meter_ring_capture_tb.sv
